/* src/sdspi_pkg.sv */
package sdspi_pkg;

    localparam logic [1:0] CMD_XFER  = 2'd0;
    localparam logic [1:0] CMD_ISSUE = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    localparam logic [1:0] INIT_NONE = 2'd0;
    localparam logic [1:0] INIT_CMD0 = 2'd1;
    localparam logic [1:0] INIT_CMD1 = 2'd2;

    localparam logic [7:0] BYTE_IDLE     = 8'hff;
    localparam logic [7:0] TOKEN_START   = 8'h40;
    localparam logic [7:0] R1_IDLE       = 8'h01;
    localparam logic [7:0] R1_READY      = 8'h00;
    localparam logic [6:0] CRC7_POLY     = 7'h09;
    localparam logic [7:0] WAKE_DEFAULT  = 8'd10;
    localparam logic [7:0] TOKEN_LEN     = 8'd5;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_WAKE  = 5'b00010,
        PH_READY = 5'b00100,
        PH_TOKEN = 5'b01000,
        PH_POLL  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select;
        logic       done_res;
        logic [7:0] response;
        logic       init_failed;
    } result_t;

    // crc7 (x^7+x^3+1) advanced over one byte, msb first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[6] ^ data[i];
            crc = {crc[5:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC7_POLY;
            end
        end
        return crc;
    endfunction

endpackage

/* src/sdspi_in_reg.sv */
module sdspi_in_reg
    import sdspi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_ready,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* src/sdspi_core.sv */
module sdspi_core
    import sdspi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] wake_count,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    phase_t      phase_reg,   phase_next;
    logic [1:0]  init_reg,    init_next;
    logic [7:0]  count_reg,   count_next;
    logic [39:0] token_reg,   token_next;
    logic [6:0]  crc_reg,     crc_next;
    logic        cs_reg,      cs_next;
    logic        res_valid_reg;
    result_t     res_reg,     res_next;
    logic        fire;

    assign item_ready = !res_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        phase_next = phase_reg;
        init_next  = init_reg;
        count_next = count_reg;
        token_next = token_reg;
        crc_next   = crc_reg;
        cs_next    = cs_reg;
        res_next   = '{tx_byte: BYTE_IDLE, tx_valid: 1'b0, chip_select: 1'b0,
                       done_res: 1'b0, response: 8'd0, init_failed: 1'b0};

        unique case (item.command)
            CMD_ISSUE:
            begin
                init_next  = INIT_NONE;
                token_next = {TOKEN_START | {2'b00, item.cmd_index}, item.argument};
                crc_next   = 7'd0;
                count_next = 8'd0;
                phase_next = PH_READY;
                res_next.tx_valid = 1'b1;
            end
            CMD_INIT:
            begin
                init_next  = INIT_NONE;
                cs_next    = 1'b1;
                count_next = (wake_count != 8'd0) ? wake_count : 8'd1;
                phase_next = PH_WAKE;
                res_next.tx_valid = 1'b1;
            end
            CMD_XFER:
            begin
                unique case (phase_reg)
                    PH_WAKE:
                    begin
                        count_next = count_reg - 8'd1;
                        res_next.tx_valid = 1'b1;
                        if (count_next == 8'd0)
                        begin
                            // wake bytes done: select the card and queue cmd0
                            cs_next    = 1'b0;
                            init_next  = INIT_CMD0;
                            token_next = {TOKEN_START, 32'd0};
                            crc_next   = 7'd0;
                            phase_next = PH_READY;
                        end
                    end
                    PH_READY:
                    begin
                        res_next.tx_valid = 1'b1;
                        if (item.rx_byte == BYTE_IDLE)
                        begin
                            res_next.tx_byte = token_reg[39:32];
                            crc_next   = crc7_byte(7'd0, token_reg[39:32]);
                            token_next = {token_reg[31:0], 8'd0};
                            count_next = TOKEN_LEN;
                            phase_next = PH_TOKEN;
                        end
                    end
                    PH_TOKEN:
                    begin
                        res_next.tx_valid = 1'b1;
                        if (count_reg >= 8'd2)
                        begin
                            // crc follows the token one byte at a time
                            res_next.tx_byte = token_reg[39:32];
                            crc_next   = crc7_byte(crc_reg, token_reg[39:32]);
                            token_next = {token_reg[31:0], 8'd0};
                            count_next = count_reg - 8'd1;
                        end
                        else if (count_reg == 8'd1)
                        begin
                            res_next.tx_byte = {crc_reg, 1'b1};
                            count_next = 8'd0;
                        end
                        else
                        begin
                            phase_next = PH_POLL;
                        end
                    end
                    PH_POLL:
                    begin
                        if (item.rx_byte[7])
                        begin
                            res_next.tx_valid = 1'b1;
                        end
                        else if (init_reg == INIT_CMD0 && item.rx_byte != R1_IDLE)
                        begin
                            res_next.done_res    = 1'b1;
                            res_next.response    = item.rx_byte;
                            res_next.init_failed = 1'b1;
                            init_next  = INIT_NONE;
                            phase_next = PH_IDLE;
                        end
                        else if (init_reg == INIT_CMD0 ||
                                 (init_reg == INIT_CMD1 && item.rx_byte != R1_READY))
                        begin
                            init_next  = INIT_CMD1;
                            token_next = {TOKEN_START | 8'd1, 32'd0};
                            crc_next   = 7'd0;
                            count_next = 8'd0;
                            phase_next = PH_READY;
                            res_next.tx_valid = 1'b1;
                        end
                        else
                        begin
                            res_next.done_res = 1'b1;
                            res_next.response = item.rx_byte;
                            init_next  = INIT_NONE;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res_next.chip_select = cs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            init_reg      <= INIT_NONE;
            count_reg     <= 8'd0;
            token_reg     <= 40'd0;
            crc_reg       <= 7'd0;
            cs_reg        <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                res_valid_reg <= item_valid;
            end
            if (fire)
            begin
                phase_reg <= phase_next;
                init_reg  <= init_next;
                count_reg <= count_next;
                token_reg <= token_next;
                crc_reg   <= crc_next;
                cs_reg    <= cs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.tx_valid)
        else $error("done result also requests an exchange");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.init_failed |-> res_reg.done_res)
        else $error("init failure reported without done");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == CMD_INIT |=> res_valid_reg && res_reg.chip_select)
        else $error("initialization did not negate chip select");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |=> $stable(phase_reg) && $stable(count_reg))
        else $error("state moved while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_next.done_res |=> phase_reg == PH_IDLE && init_reg == INIT_NONE)
        else $error("finished operation left engine busy");
`endif

endmodule

/* src/sd_spi_command_engine.sv */
// SD card SPI-mode command engine. Each transfer on the input channel is an order (issue a
// command, run initialization) or the report of one finished byte exchange with its received
// byte; each one yields exactly one result naming the next byte to send, the chip select
// level, and on completion the R1 response. One item is accepted every cycle while results
// are not stalled; an item passes through the input register, then one pass of the byte state
// machine and crc7 byte update into the result register.
// Results stalled at the output hold the input side. The configuration port is always ready
// and takes the wake byte count; write it only while no order is in flight.
module sd_spi_command_engine
    import sdspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [5:0]  cmd_index,
    input  logic [31:0] argument,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        chip_select,
    output logic        done_res,
    output logic [7:0]  response,
    output logic        init_failed
);

    logic [7:0] wake_count_reg;
    item_t      in_item;
    item_t      item;
    logic       item_valid;
    logic       item_ready;
    result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_count_reg <= WAKE_DEFAULT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wake_count_reg <= cfg_data;
        end
    end

    assign in_item = '{command: command, cmd_index: cmd_index,
                       argument: argument, rx_byte: rx_byte};

    sdspi_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    sdspi_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .wake_count (wake_count_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign tx_byte     = res.tx_byte;
    assign tx_valid    = res.tx_valid;
    assign chip_select = res.chip_select;
    assign done_res    = res.done_res;
    assign response    = res.response;
    assign init_failed = res.init_failed;

endmodule

/* dv/sd_spi_command_engine_tb.sv */
`timescale 1ns / 100ps

module sd_spi_command_engine_tb;
    import sdspi_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic [5:0] CMD0_INDEX    = 6'd0;
    localparam logic [5:0] CMD1_INDEX    = 6'd1;
    localparam int         TOKEN_REPORTS = 6;
    localparam int         PHASE_ITEMS   = 110;
    localparam int         QUIET_LIMIT   = 4000;
    localparam int         PHASE_COUNT   = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_XFER;
    logic [5:0]  cmd_index = 6'd0;
    logic [31:0] argument = 32'd0;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        chip_select;
    logic        done_res;
    logic [7:0]  response;
    logic        init_failed;

    sd_spi_command_engine u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .cmd_index   (cmd_index),
        .argument    (argument),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_byte     (tx_byte),
        .tx_valid    (tx_valid),
        .chip_select (chip_select),
        .done_res    (done_res),
        .response    (response),
        .init_failed (init_failed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // engine state mirrored by the predictor
    phase_t      eng_phase  = PH_IDLE;
    logic [1:0]  init_step  = INIT_NONE;
    logic [7:0]  byte_left  = 8'd0;
    logic [39:0] token_bits = 40'd0;
    logic [6:0]  token_crc  = 7'd0;
    logic        cs_line    = 1'b1;
    logic [7:0]  wake_count = WAKE_DEFAULT;

    item_t   pending_items[$];
    result_t expected_results[$];
    item_t   cur_item;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int items_queued = 0;
    int quiet_cycles = 0;
    int cut_left = -1;

    function automatic logic [6:0] crc7_of_token(input logic [39:0] bits);
        logic [6:0] acc;
        logic       fb;
        acc = 7'd0;
        for (int k = 39; k >= 0; k--)
        begin
            fb  = acc[6] ^ bits[k];
            acc = {acc[5:0], 1'b0};
            if (fb)
            begin
                acc = acc ^ CRC7_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void load_token(input logic [5:0] idx, input logic [31:0] arg);
        token_bits = {TOKEN_START | {2'b00, idx}, arg};
        token_crc  = 7'd0;
        byte_left  = 8'd0;
        eng_phase  = PH_READY;
    endfunction

    function automatic result_t predict_reply(input item_t it);
        result_t r;
        r.tx_byte     = BYTE_IDLE;
        r.tx_valid    = 1'b0;
        r.chip_select = 1'b1;
        r.done_res    = 1'b0;
        r.response    = 8'd0;
        r.init_failed = 1'b0;
        case (it.command)
            CMD_ISSUE:
            begin
                init_step  = INIT_NONE;
                load_token(it.cmd_index, it.argument);
                r.tx_valid = 1'b1;
            end
            CMD_INIT:
            begin
                init_step  = INIT_NONE;
                cs_line    = 1'b1;
                byte_left  = (wake_count != 8'd0) ? wake_count : 8'd1;
                eng_phase  = PH_WAKE;
                r.tx_valid = 1'b1;
            end
            CMD_XFER:
            begin
                case (eng_phase)
                    PH_WAKE:
                    begin
                        byte_left  = byte_left - 8'd1;
                        r.tx_valid = 1'b1;
                        if (byte_left == 8'd0)
                        begin
                            cs_line   = 1'b0;
                            init_step = INIT_CMD0;
                            load_token(CMD0_INDEX, 32'd0);
                        end
                    end
                    PH_READY:
                    begin
                        r.tx_valid = 1'b1;
                        if (it.rx_byte == BYTE_IDLE)
                        begin
                            token_crc  = crc7_of_token(token_bits);
                            r.tx_byte  = token_bits[39:32];
                            token_bits = token_bits << 8;
                            byte_left  = TOKEN_LEN;
                            eng_phase  = PH_TOKEN;
                        end
                    end
                    PH_TOKEN:
                    begin
                        r.tx_valid = 1'b1;
                        if (byte_left >= 8'd2)
                        begin
                            r.tx_byte  = token_bits[39:32];
                            token_bits = token_bits << 8;
                            byte_left  = byte_left - 8'd1;
                        end
                        else if (byte_left == 8'd1)
                        begin
                            r.tx_byte = {token_crc, 1'b1};
                            byte_left = 8'd0;
                        end
                        else
                        begin
                            eng_phase = PH_POLL;
                        end
                    end
                    PH_POLL:
                    begin
                        if (it.rx_byte[7])
                        begin
                            r.tx_valid = 1'b1;
                        end
                        else if (init_step == INIT_CMD0 && it.rx_byte != R1_IDLE)
                        begin
                            r.done_res    = 1'b1;
                            r.response    = it.rx_byte;
                            r.init_failed = 1'b1;
                            init_step     = INIT_NONE;
                            eng_phase     = PH_IDLE;
                        end
                        else if (init_step == INIT_CMD0 ||
                                 (init_step == INIT_CMD1 && it.rx_byte != R1_READY))
                        begin
                            init_step  = INIT_CMD1;
                            load_token(CMD1_INDEX, 32'd0);
                            r.tx_valid = 1'b1;
                        end
                        else
                        begin
                            r.done_res = 1'b1;
                            r.response = it.rx_byte;
                            init_step  = INIT_NONE;
                            eng_phase  = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        r.chip_select = cs_line;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("result %0d %s got %02h want %02h",
                                    results_checked, name, got, want));
        end
    endtask

    // item driver: holds the payload until the transfer completes
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_reply(cur_item));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    command   <= cur_item.command;
                    cmd_index <= cur_item.cmd_index;
                    argument  <= cur_item.argument;
                    rx_byte   <= cur_item.rx_byte;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_checked));
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    compare_field("tx_byte", tx_byte, want.tx_byte);
                    compare_field("tx_valid", 8'(tx_valid), 8'(want.tx_valid));
                    compare_field("chip_select", 8'(chip_select), 8'(want.chip_select));
                    compare_field("done_res", 8'(done_res), 8'(want.done_res));
                    compare_field("response", response, want.response);
                    compare_field("init_failed", 8'(init_failed), 8'(want.init_failed));
                end
                results_checked++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("sd_spi_command_engine regression: fail");
                $finish;
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [5:0] idx,
                             input logic [31:0] arg, input logic [7:0] rx);
        item_t it;
        if (cut_left == 0)
        begin
            return;
        end
        if (cut_left > 0)
        begin
            cut_left--;
        end
        it.command   = cmd;
        it.cmd_index = idx;
        it.argument  = arg;
        it.rx_byte   = rx;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_xfer(input logic [7:0] rx);
        push_item(CMD_XFER, 6'($urandom), $urandom, rx);
    endtask

    // busy bytes, ready byte, token reports, polls, then the reply
    task automatic push_exchange_body(input logic [7:0] reply);
        int busy;
        int polls;
        busy  = $urandom_range(0, 3);
        polls = $urandom_range(0, 3);
        repeat (busy) push_xfer(8'($urandom_range(0, 254)));
        push_xfer(BYTE_IDLE);
        repeat (TOKEN_REPORTS) push_xfer(8'($urandom));
        repeat (polls) push_xfer(8'h80 | 8'($urandom_range(0, 127)));
        push_xfer(reply);
    endtask

    task automatic gen_command();
        logic [5:0]  idx;
        logic [31:0] arg;
        idx = 6'($urandom);
        arg = $urandom;
        case ($urandom_range(0, 7))
            0: idx = 6'h00;
            1: idx = 6'h3f;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: arg = 32'h0000_0000;
            1: arg = 32'hffff_ffff;
            default: ;
        endcase
        push_item(CMD_ISSUE, idx, arg, 8'($urandom));
        push_exchange_body(8'($urandom_range(0, 127)));
    endtask

    task automatic gen_init();
        int          wakes;
        int          retries;
        logic [7:0]  bad;
        push_item(CMD_INIT, 6'($urandom), $urandom, 8'($urandom));
        wakes = (wake_count == 8'd0) ? 1 : int'(wake_count);
        repeat (wakes) push_xfer(8'($urandom));
        if ($urandom_range(0, 9) == 0)
        begin
            // cmd0 answered with something other than idle
            bad = 8'($urandom_range(0, 126));
            if (bad >= R1_IDLE)
            begin
                bad = bad + 8'd1;
            end
            push_exchange_body(bad);
            return;
        end
        push_exchange_body(R1_IDLE);
        retries = $urandom_range(0, 3);
        repeat (retries) push_exchange_body(8'($urandom_range(1, 127)));
        push_exchange_body(R1_READY);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_wake_count(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        wake_count = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int start;
        int pick;
        int send_plan[PHASE_COUNT];
        int stall_plan[PHASE_COUNT];
        logic [7:0] wake_plan[PHASE_COUNT];

        send_plan  = '{0, 58, 0, 25, 58, 0};
        stall_plan = '{0, 0, 58, 25, 0, 58};
        wake_plan  = '{WAKE_DEFAULT, 8'd1, 8'd255, 8'd0, 8'd4, 8'd2};
        wake_plan[4] = 8'($urandom_range(2, 8));
        wake_plan[5] = 8'($urandom_range(2, 40));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_wake_count(wake_plan[ph]);
            end
            send_idle_pct = send_plan[ph];
            stall_pct     = stall_plan[ph];
            cut_left      = -1;

            if (ph == 0)
            begin
                push_xfer(8'h00);    // exchange report while idle
                push_item(CMD_UNUSED, 6'h3f, 32'hffff_ffff, 8'hff);
                push_item(CMD_ISSUE, 6'h3f, 32'hffff_ffff, 8'h00);
                push_xfer(8'h00);
                push_xfer(BYTE_IDLE);
                for (int i = 0; i < TOKEN_REPORTS; i++)
                begin
                    push_xfer(i[0] ? 8'h00 : 8'hff);
                end
                push_xfer(8'hff);
                push_xfer(8'h7f);
                // order while busy aborts the running command
                push_item(CMD_ISSUE, 6'h00, 32'h0000_0000, 8'h00);
                push_xfer(BYTE_IDLE);
                push_xfer(8'h00);
                push_item(CMD_ISSUE, 6'h01, 32'h8000_0001, 8'hff);
                push_xfer(BYTE_IDLE);
                repeat (TOKEN_REPORTS) push_xfer(8'($urandom));
                push_xfer(R1_READY);
            end

            start = items_queued;
            gen_init();
            while (items_queued - start < PHASE_ITEMS)
            begin
                pick     = $urandom_range(0, 99);
                cut_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : -1;
                if (pick < 55 || (pick < 85 && wake_count >= 8'd32))
                begin
                    gen_command();
                end
                else if (pick < 85)
                begin
                    gen_init();
                end
                else
                begin
                    cut_left = -1;
                    repeat ($urandom_range(1, 3))
                        push_item(2'($urandom_range(0, 3)), 6'($urandom), $urandom,
                                  8'($urandom));
                end
            end
            cut_left = -1;
        end

        drain();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("sd_spi_command_engine regression: pass");
        end
        else
        begin
            $display("sd_spi_command_engine regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
src/sdspi_pkg.sv
src/sdspi_in_reg.sv
src/sdspi_core.sv
src/sd_spi_command_engine.sv
dv/sd_spi_command_engine_tb.sv
